>>> src/dtam_pkg.sv
package dtam_pkg;

  // geometry of the store
  localparam int SENSOR_COLUMNS = 16;
  localparam int SENSOR_CELLS   = 8;
  localparam int WHERE_COLUMNS  = 4;
  localparam int WHERE_CELLS    = 8;

  localparam int SLOT_COUNT = WHERE_COLUMNS * WHERE_CELLS * SENSOR_COLUMNS;
  localparam int ACT_COUNT  = SLOT_COUNT * SENSOR_CELLS;

  // field and address widths
  localparam int WCOL_W  = 2;
  localparam int WCH_W   = 3;
  localparam int SCOL_W  = 4;
  localparam int SCH_W   = 3;
  localparam int CELL_W  = $clog2(SENSOR_CELLS);
  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int ACT_AW  = SLOT_W + CELL_W;
  localparam int WIN_W   = 3;

  // fixed point activations
  localparam int LEVEL_W = 32;
  localparam int FRAC_W  = 16;
  localparam int DECAY_W = 16;
  localparam int KEEP_W  = DECAY_W + 1;
  localparam int PROD_W  = LEVEL_W + KEEP_W;

  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd655;
  localparam logic [KEEP_W-1:0]  KEEP_ONE    = KEEP_W'(1) << FRAC_W;
  localparam logic [LEVEL_W:0]   INC_ONE     = (LEVEL_W + 1)'(1) << FRAC_W;

  // tag that travels with each cell through the update pipeline
  typedef struct packed {
    logic              vld;
    logic              last;
    logic [CELL_W-1:0] k;
  } dtam_tag_t;

endpackage

>>> src/dtam_cell_update.sv
module dtam_cell_update
  import dtam_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dtam_tag_t          tag_i,
  input  logic               active_i,
  input  logic [LEVEL_W-1:0] level_i,
  input  logic [KEEP_W-1:0]  keep_i,
  output dtam_tag_t          tag_o,
  output logic [LEVEL_W-1:0] level_o
);

  logic [PROD_W-1:0]  prod;
  logic [LEVEL_W:0]   inc_sum;
  logic [LEVEL_W-1:0] dec_r;
  logic [LEVEL_W-1:0] inc_r;
  logic               sel_inc_r;
  dtam_tag_t          tag_r;

  // decay product and saturating increment
  assign prod    = PROD_W'(level_i) * PROD_W'(keep_i);
  assign inc_sum = {1'b0, level_i} + INC_ONE;

  // payload stage
  always_ff @(posedge clk) begin
    dec_r     <= prod[FRAC_W +: LEVEL_W];
    inc_r     <= inc_sum[LEVEL_W] ? {LEVEL_W{1'b1}} : inc_sum[LEVEL_W-1:0];
    sel_inc_r <= active_i;
  end

  // tag stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_i;
    end
  end

  assign tag_o   = tag_r;
  assign level_o = sel_inc_r ? inc_r : dec_r;

endmodule

>>> src/decaying_trace_argmax_memory.sv
// channel  | direction | beat contents                                    | handshake
// in_      | input     | where_column, where_choice, sensor_column, choice | in_valid/in_ready
// out_     | output    | memory_slot, winner_cell, winner_level           | out_valid/out_ready
// cfg_     | input     | decay_rate                                       | cfg_wr_en only
//
// after acceptance of a beat, the group of eight activations is streamed through
// the single read port, one cell a cycle, then through the multiply and
// write-back stages, and the winner is loaded into the result register.
// after reset all 4096 entries of the activation store are swept to zero, one entry a
// cycle, with in_ready low; configuration writes are taken during the sweep.
// a result waiting on out_ready does not block the next input beat; the block
// only holds a finished group when the previous result is still unread.
module decaying_trace_argmax_memory
  import dtam_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [DECAY_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [WCOL_W-1:0]  in_where_column,
  input  logic [WCH_W-1:0]   in_where_choice,
  input  logic [SCOL_W-1:0]  in_sensor_column,
  input  logic [SCH_W-1:0]   in_sensor_choice,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SLOT_W-1:0]  out_memory_slot,
  output logic [WIN_W-1:0]   out_winner_cell,
  output logic [LEVEL_W-1:0] out_winner_level
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_HOLD  = 4'b1000
  } dtam_state_t;

  dtam_state_t state_r, state_nxt;

  logic [DECAY_W-1:0] decay_r;
  logic [ACT_AW-1:0]  clr_addr_r;

  logic [SLOT_W-1:0]  slot_r;
  logic [SCH_W-1:0]   sch_r;
  logic [CELL_W-1:0]  rd_k_r;
  logic               iss_r;

  logic [LEVEL_W-1:0] act_mem [ACT_COUNT];
  logic [WIN_W-1:0]   win_mem [SLOT_COUNT];
  logic [LEVEL_W-1:0] rdata_r;
  dtam_tag_t          p1_tag_r;

  dtam_tag_t          p2_tag;
  logic [LEVEL_W-1:0] p2_level;
  logic [KEEP_W-1:0]  keep;

  logic [CELL_W-1:0]  best_k_r, best_k_nxt;
  logic [LEVEL_W-1:0] best_lvl_r, best_lvl_nxt;

  logic               out_valid_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [WIN_W-1:0]   out_cell_r;
  logic [LEVEL_W-1:0] out_lvl_r;

  logic               in_fire;
  logic               done;
  logic               out_free;
  logic               out_load;
  logic [SLOT_W-1:0]  slot_calc;

  logic               wr_en;
  logic [ACT_AW-1:0]  wr_addr;
  logic [LEVEL_W-1:0] wr_data;

  // handshake decode
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign done     = p2_tag.vld && p2_tag.last;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = ((state_r == ST_RUN) && done || (state_r == ST_HOLD)) && out_free;

  // slot of the addressed group
  assign slot_calc = SLOT_W'(in_sensor_column)
                   + SLOT_W'(SENSOR_COLUMNS)
                   * (SLOT_W'(in_where_choice) + SLOT_W'(WHERE_CELLS) * SLOT_W'(in_where_column));

  // decay register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= DECAY_RESET;
    end else if (cfg_wr_en) begin
      decay_r <= cfg_wr_data;
    end
  end

  assign keep = KEEP_ONE - KEEP_W'(decay_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == ACT_AW'(ACT_COUNT - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (done) state_nxt = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      iss_r      <= 1'b0;
      rd_k_r     <= '0;
      p1_tag_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + ACT_AW'(1);
      // read issue, one cell a cycle
      p1_tag_r.vld  <= iss_r;
      p1_tag_r.k    <= rd_k_r;
      p1_tag_r.last <= (rd_k_r == CELL_W'(SENSOR_CELLS - 1));
      if (in_fire) begin
        iss_r  <= 1'b1;
        rd_k_r <= '0;
      end else if (iss_r) begin
        if (rd_k_r == CELL_W'(SENSOR_CELLS - 1)) iss_r <= 1'b0;
        rd_k_r <= rd_k_r + CELL_W'(1);
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot_r <= slot_calc;
      sch_r  <= in_sensor_choice;
    end
  end

  // activation store read port
  always_ff @(posedge clk) begin
    rdata_r <= act_mem[{slot_r, rd_k_r}];
  end

  dtam_cell_update u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_i    (p1_tag_r),
    .active_i (SCH_W'(p1_tag_r.k) == sch_r),
    .level_i  (rdata_r),
    .keep_i   (keep),
    .tag_o    (p2_tag),
    .level_o  (p2_level)
  );

  // write port shared between sweep and write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {slot_r, p2_tag.k};
    wr_data = p2_level;
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (p2_tag.vld) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) act_mem[wr_addr] <= wr_data;
  end

  // winner store
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      win_mem[clr_addr_r[SLOT_W-1:0]] <= '0;
    end else if ((state_r == ST_RUN) && done) begin
      win_mem[slot_r] <= WIN_W'(best_k_nxt);
    end
  end

  // running maximum, lowest index wins ties
  always_comb begin
    best_k_nxt   = best_k_r;
    best_lvl_nxt = best_lvl_r;
    if (p2_tag.vld && ((p2_tag.k == '0) || (p2_level > best_lvl_r))) begin
      best_k_nxt   = p2_tag.k;
      best_lvl_nxt = p2_level;
    end
  end

  always_ff @(posedge clk) begin
    best_k_r   <= best_k_nxt;
    best_lvl_r <= best_lvl_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot_r <= slot_r;
      out_cell_r <= WIN_W'(best_k_nxt);
      out_lvl_r  <= best_lvl_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_memory_slot  = out_slot_r;
  assign out_winner_cell  = out_cell_r;
  assign out_winner_level = out_lvl_r;

`ifndef SYNTH
  // a new beat only starts once the previous group has fully drained
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !iss_r && !p1_tag_r.vld && !p2_tag.vld)
    else $error("input beat accepted with update pipeline busy");

  // write-back never collides with the clearing sweep
  a_no_wb_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !p1_tag_r.vld && !p2_tag.vld)
    else $error("update active during clearing sweep");

  // acceptance starts the cell stream at cell zero
  a_issue_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> iss_r && (rd_k_r == '0))
    else $error("cell stream did not start at cell zero");

  // a held group implies the previous result is still unread
  a_hold_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r)
    else $error("holding a result with a free output register");
`endif

endmodule

>>> tb/sv/trace_argmax_checker.sv
module trace_argmax_checker
  import dtam_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [DECAY_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [WCOL_W-1:0]  in_where_column,
  input  logic [WCH_W-1:0]   in_where_choice,
  input  logic [SCOL_W-1:0]  in_sensor_column,
  input  logic [SCH_W-1:0]   in_sensor_choice,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [SLOT_W-1:0]  out_memory_slot,
  input  logic [WIN_W-1:0]   out_winner_cell,
  input  logic [LEVEL_W-1:0] out_winner_level,
  output int                 mismatch_count,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [WIN_W-1:0]   win_cell;
    logic [LEVEL_W-1:0] level;
  } winner_beat_t;

  // shadow copy of the activations and the decay register
  logic [LEVEL_W-1:0] level_mem [ACT_COUNT];
  logic [DECAY_W-1:0] decay_rate;
  winner_beat_t       pending_winners [$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // update one group of cells and pick the strongest, lowest index on ties
  function automatic winner_beat_t update_group(input logic [WCOL_W-1:0] wc,
                                                input logic [WCH_W-1:0]  wch,
                                                input logic [SCOL_W-1:0] sc,
                                                input logic [SCH_W-1:0]  sch);
    logic [SLOT_W-1:0]  slot;
    logic [ACT_AW-1:0]  addr;
    logic [KEEP_W-1:0]  keep;
    logic [LEVEL_W:0]   sum;
    logic [PROD_W-1:0]  prod;
    logic [LEVEL_W-1:0] lvl;
    winner_beat_t       res;
    int                 k;
    // sensor column + 16 * (where choice + 8 * where column)
    slot = {wc, wch, sc};
    keep = (KEEP_W'(1) << FRAC_W) - KEEP_W'(decay_rate);
    res.slot     = slot;
    res.win_cell = '0;
    res.level    = '0;
    for (k = 0; k < SENSOR_CELLS; k++) begin
      addr = {slot, CELL_W'(k)};
      lvl  = level_mem[addr];
      if (k == int'(sch)) begin
        // active cell gains one, saturating
        sum = {1'b0, lvl} + ((LEVEL_W + 1)'(1) << FRAC_W);
        lvl = sum[LEVEL_W] ? '1 : sum[LEVEL_W-1:0];
      end else begin
        prod = PROD_W'(lvl) * PROD_W'(keep);
        lvl  = prod[FRAC_W +: LEVEL_W];
      end
      level_mem[addr] = lvl;
      if (k == 0 || lvl > res.level) begin
        res.level    = lvl;
        res.win_cell = WIN_W'(k);
      end
    end
    return res;
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin
    winner_beat_t want;
    if (!rst_n) begin
      foreach (level_mem[i]) level_mem[i] = '0;
      decay_rate = DECAY_RESET;
      pending_winners.delete();
    end else begin
      if (cfg_wr_en === 1'b1) decay_rate = cfg_wr_data;
      // result beat against the oldest prediction
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (pending_winners.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending: slot %0d cell %0d level %0h",
                                    out_memory_slot, out_winner_cell, out_winner_level));
        end else begin
          want = pending_winners.pop_front();
          if (out_memory_slot !== want.slot)
            report_mismatch($sformatf("memory_slot: got %0d, expected %0d",
                                      out_memory_slot, want.slot));
          if (out_winner_cell !== want.win_cell)
            report_mismatch($sformatf("winner_cell in slot %0d: got %0d, expected %0d",
                                      want.slot, out_winner_cell, want.win_cell));
          if (out_winner_level !== want.level)
            report_mismatch($sformatf("winner_level in slot %0d: got %0h, expected %0h",
                                      want.slot, out_winner_level, want.level));
        end
      end
      // accepted input beat
      if (in_valid === 1'b1 && in_ready === 1'b1)
        pending_winners.push_back(update_group(in_where_column, in_where_choice,
                                               in_sensor_column, in_sensor_choice));
    end
    outstanding <= pending_winners.size();
  end

endmodule

>>> tb/sv/tb_top.sv
module tb_top
  import dtam_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOT_GROUPS = 6;
  localparam int PHASE_BEATS = 390;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [DECAY_W-1:0] cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic [WCOL_W-1:0]  in_where_column;
  logic [WCH_W-1:0]   in_where_choice;
  logic [SCOL_W-1:0]  in_sensor_column;
  logic [SCH_W-1:0]   in_sensor_choice;
  logic               out_valid;
  logic               out_ready;
  logic [SLOT_W-1:0]  out_memory_slot;
  logic [WIN_W-1:0]   out_winner_cell;
  logic [LEVEL_W-1:0] out_winner_level;
  int                 mismatch_count;
  int                 outstanding;

  // busy groups with a favourite cell, refreshed every phase
  logic [SLOT_W-1:0]  hot_group [HOT_GROUPS];
  logic [SCH_W-1:0]   hot_cell  [HOT_GROUPS];
  bit                 send_idle;
  bit                 recv_idle;
  int                 sent_beats;

  decaying_trace_argmax_memory i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_where_column  (in_where_column),
    .in_where_choice  (in_where_choice),
    .in_sensor_column (in_sensor_column),
    .in_sensor_choice (in_sensor_choice),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_memory_slot  (out_memory_slot),
    .out_winner_cell  (out_winner_cell),
    .out_winner_level (out_winner_level)
  );

  trace_argmax_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_where_column  (in_where_column),
    .in_where_choice  (in_where_choice),
    .in_sensor_column (in_sensor_column),
    .in_sensor_choice (in_sensor_choice),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_memory_slot  (out_memory_slot),
    .out_winner_cell  (out_winner_cell),
    .out_winner_level (out_winner_level),
    .mismatch_count   (mismatch_count),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls, with stall-free stretches
  initial begin
    int stall;
    int beats;
    beats     = 0;
    out_ready = 1'b0;
    forever begin
      if (beats % 48 == 0) recv_idle = ($urandom_range(0, 3) != 0);
      stall = recv_idle ? $urandom_range(0, 16) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1 || out_ready !== 1'b1);
      beats++;
    end
  end

  // one input beat after a random gap
  task automatic send_beat(input logic [WCOL_W-1:0] wc, input logic [WCH_W-1:0] wch,
                           input logic [SCOL_W-1:0] sc, input logic [SCH_W-1:0] sch);
    int gap;
    if (sent_beats % 64 == 0) send_idle = ($urandom_range(0, 3) != 0);
    gap = send_idle ? $urandom_range(0, 16) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_where_column  <= wc;
    in_where_choice  <= wch;
    in_sensor_column <= sc;
    in_sensor_choice <= sch;
    do @(posedge clk); while (in_ready !== 1'b1);
    sent_beats++;
  endtask

  // hold off until every predicted result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_decay(input logic [DECAY_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // mostly repeated hits on a few groups so traces build up, the rest anywhere
  task automatic random_beat();
    int                h;
    logic [SLOT_W-1:0] pick;
    if ($urandom_range(0, 3) != 0) begin
      h    = $urandom_range(0, HOT_GROUPS - 1);
      pick = hot_group[h];
      send_beat(pick[8:7], pick[6:4], pick[3:0],
                ($urandom_range(0, 2) != 0) ? hot_cell[h] : SCH_W'($urandom));
    end else begin
      send_beat(WCOL_W'($urandom), WCH_W'($urandom), SCOL_W'($urandom), SCH_W'($urandom));
    end
  endtask

  initial begin
    logic [DECAY_W-1:0] decay;
    int                 phase;
    int                 k;
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    in_where_column  = '0;
    in_where_choice  = '0;
    in_sensor_column = '0;
    in_sensor_choice = '0;
    sent_beats       = 0;
    send_idle        = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset decay: corner fields, then every cell of one group in turn
    send_beat('0, '0, '0, '0);
    send_beat('1, '1, '1, '1);
    for (k = 0; k < SENSOR_CELLS; k++) send_beat('0, '0, '0, SCH_W'(k));
    send_beat(2'd1, 3'd5, 4'd9, 3'd2);
    send_beat(2'd2, 3'd2, 4'd6, 3'd5);

    // no decay: equal maxima, lowest index has to win
    drain();
    write_decay('0);
    send_beat(2'd0, 3'd3, 4'd4, 3'd3);
    send_beat(2'd0, 3'd3, 4'd4, 3'd1);
    send_beat(2'd0, 3'd3, 4'd4, 3'd6);
    send_beat(2'd3, 3'd0, 4'd15, 3'd0);

    // maximum decay shrinks every inactive cell to 1/65536 of its level
    drain();
    write_decay('1);
    send_beat('0, '0, '0, 3'd7);
    send_beat('0, '0, '0, 3'd0);
    send_beat(2'd0, 3'd3, 4'd4, 3'd2);
    send_beat('1, '1, '1, '0);

    // random phases over several decay settings
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        1:       decay = '0;
        2:       decay = '1;
        4:       decay = DECAY_RESET;
        default: decay = DECAY_W'($urandom_range(0, 8191));
      endcase
      for (k = 0; k < HOT_GROUPS; k++) begin
        hot_group[k] = SLOT_W'($urandom);
        hot_cell[k]  = SCH_W'($urandom);
      end
      drain();
      write_decay(decay);
      repeat (PHASE_BEATS) random_beat();
    end

    drain();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
